// ----- rtl/core/nsp_pkg.sv -----
// Shared constants, beat types and column type of the 3x3 neighbour similarity pattern unit.
package nsp_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int THRESHOLD_BITS = 16;
    localparam int CODE_BITS      = 8;
    localparam int CMP_BITS       = (SAMPLE_BITS + 1 > THRESHOLD_BITS) ?
                                    SAMPLE_BITS + 1 : THRESHOLD_BITS;

    localparam int ROWS       = 3;
    localparam int ROW_ABOVE  = 0;
    localparam int ROW_CENTER = 1;
    localparam int ROW_BELOW  = 2;

    localparam int BIT_RIGHT       = 0;
    localparam int BIT_UPPER_RIGHT = 1;
    localparam int BIT_UP          = 2;
    localparam int BIT_UPPER_LEFT  = 3;
    localparam int BIT_LEFT        = 4;
    localparam int BIT_LOWER_LEFT  = 5;
    localparam int BIT_DOWN        = 6;
    localparam int BIT_LOWER_RIGHT = 7;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int COUNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_above;
        logic [SAMPLE_BITS-1:0] sample_center;
        logic [SAMPLE_BITS-1:0] sample_below;
        logic                   undef_above;
        logic                   undef_center;
        logic                   undef_below;
        logic                   first_column;
        logic                   last_column;
    } in_beat_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] pattern_code;
        logic                 center_undefined;
        logic                 last_of_row;
    } out_beat_t;

    typedef struct packed {
        logic [ROWS-1:0]                  undef;
        logic [ROWS-1:0][SAMPLE_BITS-1:0] samples;
    } column_t;

    localparam column_t COLUMN_OUTSIDE = '{undef: '1, samples: '0};

endpackage

// ----- rtl/core/nsp_lane.sv -----
// One comparison lane: tests a single neighbour against the center sample.
module nsp_lane (
    input  logic [nsp_pkg::SAMPLE_BITS-1:0]    neighbour_sample,
    input  logic                               neighbour_undef,
    input  logic [nsp_pkg::SAMPLE_BITS-1:0]    center_sample,
    input  logic [nsp_pkg::THRESHOLD_BITS-1:0] threshold,
    output logic                               hit
);

    logic [nsp_pkg::SAMPLE_BITS:0] diff;
    logic [nsp_pkg::SAMPLE_BITS:0] magnitude;

    always_comb
    begin
        diff = {neighbour_sample[nsp_pkg::SAMPLE_BITS-1], neighbour_sample}
             - {center_sample[nsp_pkg::SAMPLE_BITS-1], center_sample};
        magnitude = diff[nsp_pkg::SAMPLE_BITS] ? -diff : diff;
        hit = !neighbour_undef &&
              (nsp_pkg::CMP_BITS'(magnitude) <= nsp_pkg::CMP_BITS'(threshold));
    end

endmodule

// ----- rtl/core/nsp_merge.sv -----
// Merging stage: combines the eight lane results into one result beat.
module nsp_merge (
    input  logic [nsp_pkg::CODE_BITS-1:0] lane_hits,
    input  logic                          center_undef,
    input  logic                          last,
    output nsp_pkg::out_beat_t            result
);

    always_comb
    begin
        result.pattern_code     = center_undef ? '0 : lane_hits;
        result.center_undefined = center_undef;
        result.last_of_row      = last;
    end

endmodule

// ----- rtl/core/nsp_out_fifo.sv -----
// Output queue that takes up to two result beats per cycle and releases one per cycle while out_ready is high.
module nsp_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push0,
    input  logic               push1,
    input  nsp_pkg::out_beat_t data0,
    input  nsp_pkg::out_beat_t data1,
    output logic               room_for_two,
    output logic               out_valid,
    input  logic               out_ready,
    output nsp_pkg::out_beat_t out_data
);

    nsp_pkg::out_beat_t                entries_reg [nsp_pkg::FIFO_DEPTH];
    logic [nsp_pkg::PTR_BITS-1:0]      wr_ptr_reg;
    logic [nsp_pkg::PTR_BITS-1:0]      wr_ptr_next;
    logic [nsp_pkg::PTR_BITS-1:0]      rd_ptr_reg;
    logic [nsp_pkg::PTR_BITS-1:0]      rd_ptr_next;
    logic [nsp_pkg::COUNT_BITS-1:0]    count_reg;
    logic [nsp_pkg::COUNT_BITS-1:0]    count_next;
    logic                              pop;
    logic [nsp_pkg::PTR_BITS-1:0]      wr_ptr_plus_one;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = entries_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= nsp_pkg::COUNT_BITS'(nsp_pkg::FIFO_DEPTH - 2));
    assign wr_ptr_plus_one = wr_ptr_reg + nsp_pkg::PTR_BITS'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + nsp_pkg::PTR_BITS'(push0) + nsp_pkg::PTR_BITS'(push1);
        rd_ptr_next = rd_ptr_reg + nsp_pkg::PTR_BITS'(pop);
        count_next  = count_reg + nsp_pkg::COUNT_BITS'(push0)
                    + nsp_pkg::COUNT_BITS'(push1) - nsp_pkg::COUNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            entries_reg[wr_ptr_reg] <= data0;
        end
        if (push1)
        begin
            entries_reg[wr_ptr_plus_one] <= data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= nsp_pkg::COUNT_BITS'(nsp_pkg::FIFO_DEPTH))
        else $error("Output queue count exceeds its depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        push1 |-> (push0 && room_for_two))
        else $error("Second result beat pushed without a first one or without room.");

endmodule

// ----- rtl/core/neighbour_similarity_pattern_3x3_unit.sv -----
// Top level of the 3x3 neighbour similarity pattern unit: column window, lanes and output queue.
// Throughput: one column beat per cycle while in_ready is high; a column that ends a row
// yields two result beats unless it also begins the row. A pixel's result enters the output
// queue at the edge that accepts its right neighbour column (or the row-ending column itself).
// The two-result write port and four-entry output queue set the rate; input stalls only
// when fewer than two queue entries are free.
// Reset clears the column window to undefined, the threshold to zero and empties the queue.
module neighbour_similarity_pattern_3x3_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  nsp_pkg::in_beat_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output nsp_pkg::out_beat_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nsp_pkg::THRESHOLD_BITS-1:0] cfg_data
);

    logic [nsp_pkg::THRESHOLD_BITS-1:0] threshold_reg;
    nsp_pkg::column_t                   left_col_reg;
    nsp_pkg::column_t                   left_col_next;
    nsp_pkg::column_t                   mid_col_reg;
    nsp_pkg::column_t                   mid_col_next;
    logic                               mid_valid_reg;
    logic                               mid_valid_next;

    logic                               accept;
    logic                               emit_a;
    logic                               emit_b;
    nsp_pkg::column_t                   new_col;
    nsp_pkg::column_t                   left_after;
    nsp_pkg::column_t                   win_left  [2];
    nsp_pkg::column_t                   win_mid   [2];
    nsp_pkg::column_t                   win_right [2];
    logic [nsp_pkg::SAMPLE_BITS-1:0]    nb_sample [2][nsp_pkg::CODE_BITS];
    logic                               nb_undef  [2][nsp_pkg::CODE_BITS];
    logic [nsp_pkg::CODE_BITS-1:0]      lane_hits [2];
    logic                               emit_last [2];
    nsp_pkg::out_beat_t                 results   [2];
    logic                               room_for_two;
    logic                               push0;
    logic                               push1;
    nsp_pkg::out_beat_t                 data0;

    assign cfg_ready = 1'b1;
    assign in_ready  = room_for_two;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        new_col.samples[nsp_pkg::ROW_ABOVE]  = in_data.sample_above;
        new_col.samples[nsp_pkg::ROW_CENTER] = in_data.sample_center;
        new_col.samples[nsp_pkg::ROW_BELOW]  = in_data.sample_below;
        new_col.undef[nsp_pkg::ROW_ABOVE]    = in_data.undef_above;
        new_col.undef[nsp_pkg::ROW_CENTER]   = in_data.undef_center;
        new_col.undef[nsp_pkg::ROW_BELOW]    = in_data.undef_below;

        emit_a     = !in_data.first_column && mid_valid_reg;
        emit_b     = in_data.last_column;
        left_after = emit_a ? mid_col_reg : nsp_pkg::COLUMN_OUTSIDE;

        win_left[0]  = left_col_reg;
        win_mid[0]   = mid_col_reg;
        win_right[0] = new_col;
        emit_last[0] = 1'b0;
        win_left[1]  = left_after;
        win_mid[1]   = new_col;
        win_right[1] = nsp_pkg::COLUMN_OUTSIDE;
        emit_last[1] = 1'b1;

        if (in_data.last_column)
        begin
            left_col_next  = nsp_pkg::COLUMN_OUTSIDE;
            mid_col_next   = nsp_pkg::COLUMN_OUTSIDE;
            mid_valid_next = 1'b0;
        end
        else
        begin
            left_col_next  = left_after;
            mid_col_next   = new_col;
            mid_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        for (int e = 0; e < 2; e++)
        begin
            nb_sample[e][nsp_pkg::BIT_RIGHT]       = win_right[e].samples[nsp_pkg::ROW_CENTER];
            nb_undef[e][nsp_pkg::BIT_RIGHT]        = win_right[e].undef[nsp_pkg::ROW_CENTER];
            nb_sample[e][nsp_pkg::BIT_UPPER_RIGHT] = win_right[e].samples[nsp_pkg::ROW_ABOVE];
            nb_undef[e][nsp_pkg::BIT_UPPER_RIGHT]  = win_right[e].undef[nsp_pkg::ROW_ABOVE];
            nb_sample[e][nsp_pkg::BIT_UP]          = win_mid[e].samples[nsp_pkg::ROW_ABOVE];
            nb_undef[e][nsp_pkg::BIT_UP]           = win_mid[e].undef[nsp_pkg::ROW_ABOVE];
            nb_sample[e][nsp_pkg::BIT_UPPER_LEFT]  = win_left[e].samples[nsp_pkg::ROW_ABOVE];
            nb_undef[e][nsp_pkg::BIT_UPPER_LEFT]   = win_left[e].undef[nsp_pkg::ROW_ABOVE];
            nb_sample[e][nsp_pkg::BIT_LEFT]        = win_left[e].samples[nsp_pkg::ROW_CENTER];
            nb_undef[e][nsp_pkg::BIT_LEFT]         = win_left[e].undef[nsp_pkg::ROW_CENTER];
            nb_sample[e][nsp_pkg::BIT_LOWER_LEFT]  = win_left[e].samples[nsp_pkg::ROW_BELOW];
            nb_undef[e][nsp_pkg::BIT_LOWER_LEFT]   = win_left[e].undef[nsp_pkg::ROW_BELOW];
            nb_sample[e][nsp_pkg::BIT_DOWN]        = win_mid[e].samples[nsp_pkg::ROW_BELOW];
            nb_undef[e][nsp_pkg::BIT_DOWN]         = win_mid[e].undef[nsp_pkg::ROW_BELOW];
            nb_sample[e][nsp_pkg::BIT_LOWER_RIGHT] = win_right[e].samples[nsp_pkg::ROW_BELOW];
            nb_undef[e][nsp_pkg::BIT_LOWER_RIGHT]  = win_right[e].undef[nsp_pkg::ROW_BELOW];
        end
    end

    for (genvar e = 0; e < 2; e++)
    begin : g_emit
        for (genvar k = 0; k < nsp_pkg::CODE_BITS; k++)
        begin : g_lane
            nsp_lane u_lane (
                .neighbour_sample (nb_sample[e][k]),
                .neighbour_undef  (nb_undef[e][k]),
                .center_sample    (win_mid[e].samples[nsp_pkg::ROW_CENTER]),
                .threshold        (threshold_reg),
                .hit              (lane_hits[e][k])
            );
        end

        nsp_merge u_merge (
            .lane_hits    (lane_hits[e]),
            .center_undef (win_mid[e].undef[nsp_pkg::ROW_CENTER]),
            .last         (emit_last[e]),
            .result       (results[e])
        );
    end

    assign push0 = accept && (emit_a || emit_b);
    assign push1 = accept && emit_a && emit_b;
    assign data0 = emit_a ? results[0] : results[1];

    nsp_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push0        (push0),
        .push1        (push1),
        .data0        (data0),
        .data1        (results[1]),
        .room_for_two (room_for_two),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            left_col_reg  <= nsp_pkg::COLUMN_OUTSIDE;
            mid_col_reg   <= nsp_pkg::COLUMN_OUTSIDE;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                threshold_reg <= cfg_data;
            end
            if (accept)
            begin
                left_col_reg  <= left_col_next;
                mid_col_reg   <= mid_col_next;
                mid_valid_reg <= mid_valid_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last_column) |=> (!mid_valid_reg && (mid_col_reg.undef == '1)))
        else $error("Column window not cleared after the beat that ends a row.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.center_undefined) |-> (out_data.pattern_code == '0))
        else $error("Result beat with undefined center carries a nonzero code.");

endmodule
